>>> hdl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared constants and types for the voxel collision checker.
// ----------------------------------------------------------------------------
package vcc_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [1:0] MODE_STATE  = 2'd0;
   localparam logic [1:0] MODE_VOXEL  = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] REG_CLEARANCE = 3'd0;
   localparam logic [2:0] REG_RADIUS    = 3'd1;
   localparam logic [2:0] REG_HEIGHT    = 3'd2;
   localparam logic [2:0] REG_FRAMES    = 3'd3;
   localparam logic [2:0] REG_RATE      = 3'd4;
   localparam logic [2:0] REG_ARM       = 3'd5;

   localparam int AXIS_W = 27;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
      logic [23:0]        cell_size;
      logic               cell_occupied;
   } req_type;

   typedef struct packed {
      logic [19:0] clearance;
      logic [19:0] body_radius;
      logic [19:0] body_height;
      logic [7:0]  lookahead_frames;
      logic [9:0]  capture_rate;
      logic [21:0] arm_height;
   } cfg_type;

   function automatic logic [AXIS_W-1:0] axis_dist(input logic signed [31:0] pose,
                                                   input logic signed [31:0] ctr,
                                                   input logic [23:0] size);
      logic signed [33:0] d;
      logic signed [33:0] ad;
      logic signed [35:0] e;
      logic [35:0]        ae;
      d  = 34'(pose) - 34'(ctr);
      ad = d[33] ? -d : d;
      e  = 36'({ad, 1'b0}) - 36'({12'd0, size});
      ae = e[35] ? 36'(-e) : 36'(e);
      axis_dist = (ae > 36'(1 << 26)) ? AXIS_W'(1 << 26) : ae[AXIS_W-1:0];
   endfunction

endpackage

>>> hdl/vcc_if.sv
// ----------------------------------------------------------------------------
// vcc_if
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface vcc_req_if import vcc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vcc_rsp_if ();
   logic valid;
   logic ready;
   logic collision_free;
   modport source (output valid, output collision_free, input ready);
   modport sink (input valid, input collision_free, output ready);
endinterface

interface vcc_csr_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [21:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/voxel_collision_checker.sv
// Voxel collision checker for one vehicle.
// State item: for each of the 3 axes, a multiply, a divider start and a serial divide.
// Voxel item: a distance per axis, the squares of the two plane distances, a root start, a serial root, then the tests.
// Finish, clear and ignored items stay in idle; a finish holds the request until its response goes.
// Synchronous active-high reset restores register defaults and clears all flags.
// ----------------------------------------------------------------------------
// voxel_collision_checker
// Sequencer around a shared multiplier, a serial divider and a serial root.
// ----------------------------------------------------------------------------
module voxel_collision_checker import vcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   vcc_req_if.sink req,
   vcc_rsp_if.source rsp,
   vcc_csr_if.sink csr
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PMUL  = 4'd1;
   localparam logic [3:0] ST_PDIV  = 4'd2;
   localparam logic [3:0] ST_PWAIT = 4'd3;
   localparam logic [3:0] ST_VSQ   = 4'd4;
   localparam logic [3:0] ST_VSQ2  = 4'd5;
   localparam logic [3:0] ST_VROOT = 4'd6;
   localparam logic [3:0] ST_VWAIT = 4'd7;
   localparam logic [3:0] ST_VT1   = 4'd8;
   localparam logic [3:0] ST_VT2   = 4'd9;
   localparam logic [3:0] ST_VT3   = 4'd10;
   localparam logic [3:0] ST_VT4   = 4'd11;

   cfg_type cfg_ff;
   req_type item_ff;
   logic [3:0] state_ff, state_in;
   logic armed_ff, open_ff, hit_ff;
   logic signed [31:0] pose_ff [3];
   logic [1:0] axis_ff;
   logic rsp_valid_ff, rsp_free_ff;
   logic signed [63:0] prod_ff;
   logic [26:0] ax_ff, ay_ff, h_ff, r_ff;
   logic [55:0] acc_ff;
   logic signed [29:0] dr_ff, dh_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic div_start, div_done, sq_start, sq_done;
   logic [40:0] div_q;
   logic [26:0] sq_root;
   logic [9:0] rate;
   logic signed [31:0] cur_pos, cur_vel, cur_cell, cur_pose;
   logic signed [42:0] quo_s;
   logic signed [43:0] sum_s;
   logic signed [31:0] sat;
   logic accept;
   logic [26:0] a_axis;
   logic signed [28:0] bigR, bigC, bigH;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.collision_free = rsp_free_ff;
   assign rate = (cfg_ff.capture_rate == 10'd0) ? 10'd1 : cfg_ff.capture_rate;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            cur_pos = item_ff.pos_x; cur_vel = item_ff.vel_x;
            cur_cell = item_ff.cell_x; cur_pose = pose_ff[0];
         end
         2'd1: begin
            cur_pos = item_ff.pos_y; cur_vel = item_ff.vel_y;
            cur_cell = item_ff.cell_y; cur_pose = pose_ff[1];
         end
         default: begin
            cur_pos = item_ff.pos_z; cur_vel = item_ff.vel_z;
            cur_cell = item_ff.cell_z; cur_pose = pose_ff[2];
         end
      endcase
   end

   assign bigR = 29'(cfg_ff.body_radius) <<< 1;
   assign bigC = 29'(cfg_ff.clearance) <<< 1;
   assign bigH = 29'(cfg_ff.body_height);
   assign a_axis = axis_dist(cur_pose, cur_cell, item_ff.cell_size);

   always_comb begin
      mul_a = cur_vel;
      mul_b = 32'(cfg_ff.lookahead_frames);
      case (state_ff)
         ST_VSQ: begin mul_a = 32'(ax_ff); mul_b = 32'(ax_ff); end
         ST_VSQ2: begin mul_a = 32'(ay_ff); mul_b = 32'(ay_ff); end
         ST_VT2: begin mul_a = 32'(dr_ff); mul_b = 32'(dr_ff); end
         ST_VT3: begin mul_a = 32'(dh_ff); mul_b = 32'(dh_ff); end
         ST_VT4: begin mul_a = 32'(bigC); mul_b = 32'(bigC); end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   assign div_start = (state_ff == ST_PDIV);
   vcc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff[63] ? 41'(-prod_ff) : prod_ff[40:0]),
      .divisor(rate), .done(div_done), .quotient(div_q)
   );

   assign sq_start = (state_ff == ST_VROOT);
   vcc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand(acc_ff[53:0]), .done(sq_done), .root(sq_root)
   );

   always_comb begin
      quo_s = prod_ff[63] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
      sum_s = 44'(cur_pos) + 44'(quo_s);
      if (sum_s > 44'sd2147483647) sat = 32'sh7fffffff;
      else if (sum_s < -44'sd2147483648) sat = 32'sh80000000;
      else sat = sum_s[31:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            case (req.data.mode)
               MODE_STATE: state_in =
                  (armed_ff || (req.data.pos_z > $signed({10'd0, cfg_ff.arm_height})))
                  ? ST_PMUL : ST_IDLE;
               MODE_VOXEL: state_in = (open_ff && !hit_ff && req.data.cell_occupied)
                  ? ST_VT1 : ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PMUL: state_in = ST_PDIV;
         ST_PDIV: state_in = ST_PWAIT;
         ST_PWAIT: if (div_done) state_in = (axis_ff == 2'd2) ? ST_IDLE : ST_PMUL;
         ST_VT1: state_in = (axis_ff == 2'd2) ? ST_VSQ : ST_VT1;
         ST_VSQ: state_in = ST_VSQ2;
         ST_VSQ2: state_in = ST_VROOT;
         ST_VROOT: state_in = ST_VWAIT;
         ST_VWAIT: if (sq_done) state_in = ST_VT2;
         ST_VT2: state_in = ST_VT3;
         ST_VT3: state_in = ST_VT4;
         ST_VT4: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req.data;
      case (state_ff)
         ST_PMUL: prod_ff <= mul_p;
         ST_VSQ: acc_ff <= 56'(mul_p);
         ST_VSQ2: acc_ff <= acc_ff + 56'(mul_p);
         ST_VT2: acc_ff <= 56'(mul_p);
         ST_VT3: acc_ff <= acc_ff + 56'(mul_p);
         default: ;
      endcase
      if (state_ff == ST_VT1) begin
         case (axis_ff)
            2'd0: ax_ff <= a_axis;
            2'd1: ay_ff <= a_axis;
            default: h_ff <= a_axis;
         endcase
      end
      if (state_ff == ST_VWAIT && sq_done) begin
         r_ff <= sq_root;
         dr_ff <= 30'(sq_root) - 30'(bigR);
         dh_ff <= 30'(h_ff) - 30'(bigH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         armed_ff <= 1'b0;
         open_ff <= 1'b0;
         hit_ff <= 1'b0;
         axis_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         rsp_free_ff <= 1'b0;
         pose_ff[0] <= '0;
         pose_ff[1] <= '0;
         pose_ff[2] <= '0;
         cfg_ff.clearance <= 20'd32768;
         cfg_ff.body_radius <= 20'd19661;
         cfg_ff.body_height <= 20'd13107;
         cfg_ff.lookahead_frames <= 8'd10;
         cfg_ff.capture_rate <= 10'd100;
         cfg_ff.arm_height <= 22'd6554;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr.valid) begin
            case (csr.index)
               REG_CLEARANCE: cfg_ff.clearance <= csr.wdata[19:0];
               REG_RADIUS: cfg_ff.body_radius <= csr.wdata[19:0];
               REG_HEIGHT: cfg_ff.body_height <= csr.wdata[19:0];
               REG_FRAMES: cfg_ff.lookahead_frames <= csr.wdata[7:0];
               REG_RATE: cfg_ff.capture_rate <= csr.wdata[9:0];
               REG_ARM: cfg_ff.arm_height <= csr.wdata[21:0];
               default: ;
            endcase
         end
         if (accept) begin
            axis_ff <= 2'd0;
            case (req.data.mode)
               MODE_STATE: begin
                  if (armed_ff ||
                      (req.data.pos_z > $signed({10'd0, cfg_ff.arm_height}))) begin
                     armed_ff <= 1'b1;
                     open_ff <= 1'b1;
                     hit_ff <= 1'b0;
                  end else begin
                     open_ff <= 1'b0;
                  end
               end
               MODE_FINISH: if (open_ff) begin
                  open_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  rsp_free_ff <= !hit_ff;
               end
               MODE_CLEAR: armed_ff <= 1'b0;
               default: ;
            endcase
         end
         if (state_ff == ST_PWAIT && div_done) begin
            pose_ff[axis_ff] <= sat;
            axis_ff <= axis_ff + 2'd1;
         end
         if (state_ff == ST_VT1) axis_ff <= axis_ff + 2'd1;
         if (state_ff == ST_VT4) begin
            if ((bigR > 29'(r_ff) && (bigH + bigC) > 29'(h_ff)) ||
                ((bigR + bigC) > 29'(r_ff) && bigH > 29'(h_ff)) ||
                (56'(mul_p) > acc_ff))
               hit_ff <= 1'b1;
         end
      end
   end
endmodule

>>> hdl/vcc_divider.sv
// ----------------------------------------------------------------------------
// vcc_divider
// Restoring divider, one quotient bit per cycle, 41-bit magnitude by 10-bit.
// ----------------------------------------------------------------------------
module vcc_divider import vcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [40:0] dividend,
   input  logic [9:0]  divisor,
   output logic        done,
   output logic [40:0] quotient
);
   logic [40:0] q_ff, q_in;
   logic [10:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [10:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[9:0], q_ff[40]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = 6'd41;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[39:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

>>> hdl/vcc_sqrt.sv
// ----------------------------------------------------------------------------
// vcc_sqrt
// Bit-by-bit integer square root of a 54-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vcc_sqrt import vcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [53:0] radicand,
   output logic        done,
   output logic [26:0] root
);
   logic [55:0] s_ff, s_in;
   logic [55:0] res_ff, res_in;
   logic [55:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [55:0] sum;

   always_comb begin
      s_in = s_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum = res_ff + bit_ff;
      if (start) begin
         s_in = {2'b00, radicand};
         res_in = '0;
         bit_in = 56'd1 << 54;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (s_ff >= sum) begin
            s_in = s_ff - sum;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[26:0];
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for voxel_collision_checker. Drives state, voxel, finish and
// clear requests with random idling on both channels, predicts every answer
// from a behavioral copy of the checker state and compares each response.
// ----------------------------------------------------------------------------
import vcc_pkg::*;

class collision_scoreboard;
   cfg_type cfg;
   bit      armed;
   bit      query_open;
   bit      hit_found;
   int      pose [3];
   bit      answers [$];
   int      errors;
   int      requests;
   int      responses;
   int      hits_seen;

   function new();
      cfg.clearance        = 20'd32768;
      cfg.body_radius      = 20'd19661;
      cfg.body_height      = 20'd13107;
      cfg.lookahead_frames = 8'd10;
      cfg.capture_rate     = 10'd100;
      cfg.arm_height       = 22'd6554;
      pose = '{0, 0, 0};
   endfunction

   function void write_reg(logic [2:0] index, logic [21:0] value);
      case (index)
         REG_CLEARANCE: cfg.clearance = value[19:0];
         REG_RADIUS:    cfg.body_radius = value[19:0];
         REG_HEIGHT:    cfg.body_height = value[19:0];
         REG_FRAMES:    cfg.lookahead_frames = value[7:0];
         REG_RATE:      cfg.capture_rate = value[9:0];
         REG_ARM:       cfg.arm_height = value;
         default: ;
      endcase
   endfunction

   function longint axis_gap(int p, int c, logic [23:0] size);
      longint d;
      d = longint'(p) - longint'(c);
      if (d < 0) d = -d;
      d = 2 * d - longint'(size);
      if (d < 0) d = -d;
      if (d > (longint'(1) << 26)) d = longint'(1) << 26;
      return d;
   endfunction

   function longint root_floor(longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = longint'(1) << 54;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function bit shape_hit(req_type r);
      longint ax, ay, h, rr, br, cl, hh, dr, dh;
      ax = axis_gap(pose[0], r.cell_x, r.cell_size);
      ay = axis_gap(pose[1], r.cell_y, r.cell_size);
      h  = axis_gap(pose[2], r.cell_z, r.cell_size);
      rr = root_floor(longint'(ax * ax + ay * ay));
      br = 2 * longint'(cfg.body_radius);
      cl = 2 * longint'(cfg.clearance);
      hh = longint'(cfg.body_height);
      dr = rr - br;
      dh = h - hh;
      if (br > rr && hh + cl > h) return 1;
      if (br + cl > rr && hh > h) return 1;
      return (cl * cl > dr * dr + dh * dh);
   endfunction

   function int project(int p, int v);
      longint rate;
      longint s;
      rate = (cfg.capture_rate != 0) ? longint'(cfg.capture_rate) : 1;
      s = longint'(p) + (longint'(v) * longint'(cfg.lookahead_frames)) / rate;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return int'(s);
   endfunction

   function void note_request(req_type r);
      requests++;
      case (r.mode)
         MODE_STATE: begin
            if (!armed) begin
               if (longint'(r.pos_z) > longint'(cfg.arm_height)) begin
                  armed = 1;
               end else begin
                  query_open = 0;
                  return;
               end
            end
            pose[0] = project(r.pos_x, r.vel_x);
            pose[1] = project(r.pos_y, r.vel_y);
            pose[2] = project(r.pos_z, r.vel_z);
            query_open = 1;
            hit_found = 0;
         end
         MODE_VOXEL: begin
            if (query_open && !hit_found && r.cell_occupied)
               hit_found = shape_hit(r);
         end
         MODE_FINISH: begin
            if (query_open) begin
               query_open = 0;
               answers.push_back(!hit_found);
               if (hit_found) hits_seen++;
            end
         end
         default: armed = 0;
      endcase
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_response(bit collision_free);
      bit want;
      responses++;
      if (answers.size() == 0) begin
         report($sformatf("response %0d arrived with none pending", collision_free));
         return;
      end
      want = answers.pop_front();
      if (want != collision_free)
         report($sformatf("collision_free %0d, want %0d", collision_free, want));
   endtask
endclass

module tb_top;
   localparam int LIMIT = 1000000;

   logic clock;
   logic reset;
   int   cycles;
   bit   quiet;

   vcc_req_if req_ch ();
   vcc_rsp_if rsp_ch ();
   vcc_csr_if csr_ch ();

   collision_scoreboard sb;

   voxel_collision_checker i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("voxel_collision_checker test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.collision_free);
         rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 31);
      end
   end

   function automatic req_type blank(logic [1:0] mode);
      req_type r;
      r = '0;
      r.mode = mode;
      return r;
   endfunction

   function automatic req_type state_req(int px, int py, int pz, int vx, int vy, int vz);
      req_type r;
      r = blank(MODE_STATE);
      r.pos_x = px; r.pos_y = py; r.pos_z = pz;
      r.vel_x = vx; r.vel_y = vy; r.vel_z = vz;
      return r;
   endfunction

   function automatic req_type voxel_req(int cx, int cy, int cz, logic [23:0] size, bit occ);
      req_type r;
      r = blank(MODE_VOXEL);
      r.cell_x = cx; r.cell_y = cy; r.cell_z = cz;
      r.cell_size = size;
      r.cell_occupied = occ;
      return r;
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r.mode = 2'($urandom_range(3));
      r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
      r.vel_x = $urandom; r.vel_y = $urandom; r.vel_z = $urandom;
      r.cell_x = $urandom; r.cell_y = $urandom; r.cell_z = $urandom;
      r.cell_size = 24'($urandom);
      r.cell_occupied = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic send(req_type r);
      while (!quiet && $urandom_range(99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [21:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic load_cfg(cfg_type c);
      write_csr(REG_CLEARANCE, 22'(c.clearance));
      write_csr(REG_RADIUS, 22'(c.body_radius));
      write_csr(REG_HEIGHT, 22'(c.body_height));
      write_csr(REG_FRAMES, 22'(c.lookahead_frames));
      write_csr(REG_RATE, 22'(c.capture_rate));
      write_csr(REG_ARM, c.arm_height);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_query();
      int px, py, pz, vx, vy, vz, n, k;
      px = $urandom_range(65536 * 40) - 65536 * 20;
      py = $urandom_range(65536 * 40) - 65536 * 20;
      pz = ($urandom_range(99) < 85) ? int'(sb.cfg.arm_height) + $urandom_range(65536 * 4)
                                     : $urandom_range(sb.cfg.arm_height);
      vx = $urandom_range(131072) - 65536;
      vy = $urandom_range(131072) - 65536;
      vz = $urandom_range(131072) - 65536;
      if ($urandom_range(99) < 10) send(blank(MODE_CLEAR));
      send(state_req(px, py, pz, vx, vy, vz));
      n = $urandom_range(4);
      for (k = 0; k < n; k++)
         send(voxel_req(px + $urandom_range(65536 * 6) - 65536 * 3,
                        py + $urandom_range(65536 * 6) - 65536 * 3,
                        pz + $urandom_range(65536 * 6) - 65536 * 3,
                        24'($urandom_range(131072)), $urandom_range(99) < 80));
      if ($urandom_range(99) < 92) send(blank(MODE_FINISH));
   endtask

   task automatic random_phase(int items);
      int start;
      start = sb.requests;
      while (sb.requests - start < items) begin
         if ($urandom_range(99) < 80) run_query();
         else send(noise_req());
      end
   endtask

   initial begin
      cfg_type c;
      sb = new();
      cycles = 0;
      quiet = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.index = '0;
      csr_ch.wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      load_cfg(sb.cfg);

      send(blank(MODE_FINISH));
      send(state_req(0, 0, 0, 0, 0, 0));
      send(voxel_req(0, 0, 0, 24'd65536, 1));
      send(blank(MODE_FINISH));
      send(state_req(0, 0, 65536, 0, 0, 0));
      send(voxel_req(0, 0, 65536, 24'd65536, 0));
      send(voxel_req(0, 0, 65536, 24'd65536, 1));
      send(voxel_req(32'h40000000, 0, 0, 24'd65536, 1));
      send(blank(MODE_FINISH));
      send(state_req(0, 0, 65536, 0, 0, 0));
      send(voxel_req(32'h40000000, 32'h40000000, 0, 24'hFFFFFF, 1));
      send(blank(MODE_CLEAR));
      send(blank(MODE_FINISH));
      send(state_req(0, 0, 0, 0, 0, 0));
      send(blank(MODE_FINISH));
      send(state_req(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h80000000, 32'h80000000));
      send(state_req(32'h80000000, 32'h7FFFFFFF, 65536, 32'h80000000, 32'h7FFFFFFF, 0));
      send(voxel_req(32'h80000000, 32'h7FFFFFFF, 65536, 24'hFFFFFF, 1));
      send(blank(MODE_FINISH));
      send(state_req(0, 0, 65536, 0, 0, 0));
      send(voxel_req(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 24'd0, 1));
      send(blank(MODE_FINISH));
      drain();

      random_phase(100);
      drain();

      c = '0;
      load_cfg(c);
      quiet = 1;
      random_phase(100);
      quiet = 0;
      drain();

      c.clearance = 20'hFFFFF; c.body_radius = 20'hFFFFF; c.body_height = 20'hFFFFF;
      c.lookahead_frames = 8'hFF; c.capture_rate = 10'd1; c.arm_height = 22'h3FFFFF;
      load_cfg(c);
      random_phase(60);
      drain();

      c.capture_rate = 10'h3FF; c.arm_height = 22'd0;
      load_cfg(c);
      random_phase(60);
      drain();

      repeat (2) begin
         c.clearance = 20'($urandom_range(20'h1FFFF));
         c.body_radius = 20'($urandom_range(20'h1FFFF));
         c.body_height = 20'($urandom_range(20'h1FFFF));
         c.lookahead_frames = 8'($urandom);
         c.capture_rate = 10'($urandom_range(1023, 1));
         c.arm_height = 22'($urandom_range(65536 * 2));
         load_cfg(c);
         random_phase(80);
         drain();
      end

      $display("summary: %0d requests, %0d responses, %0d with a hit, over six settings",
               sb.requests, sb.responses, sb.hits_seen);
      if (sb.answers.size() != 0) sb.report("expected responses left over");
      if (sb.errors == 0) begin
         $display("voxel_collision_checker test passed");
      end else begin
         $display("voxel_collision_checker test failed");
      end
      $finish;
   end
endmodule

>>> files.f
hdl/vcc_pkg.sv
hdl/vcc_if.sv
hdl/vcc_divider.sv
hdl/vcc_sqrt.sv
hdl/voxel_collision_checker.sv
tb/sv/tb_top.sv
